### sv/rmsd_pkg.sv
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared types, codes and panel geometry of the RGB matrix scan driver.
// ----------------------------------------------------------------------------
`default_nettype none

package rmsd_pkg;

    localparam int PANEL_ROWS    = 32;
    localparam int PANEL_COLUMNS = 32;
    localparam int HALF_ROWS     = PANEL_ROWS / 2;

    localparam int ROW_W   = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
    localparam int COL_W   = $clog2(PANEL_COLUMNS);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int WORD_W  = 6;
    localparam int COORD_W = 8;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [COL_W:0]    col_cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [3:0]        row_addr_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t ROWS_S     = COORD_W'(PANEL_ROWS);
    localparam coord_t COLS_S     = COORD_W'(PANEL_COLUMNS);
    localparam coord_t HALF_S     = COORD_W'(HALF_ROWS);
    localparam coord_t SCAN_ROWS_S = COORD_W'(2 * HALF_ROWS);
    localparam coord_t ROWS_LAST  = COORD_W'(PANEL_ROWS - 1);
    localparam coord_t COLS_LAST  = COORD_W'(PANEL_COLUMNS - 1);

    localparam logic [6:0] BRIGHT_MAX = 7'd100;
    localparam logic [6:0] BRIGHT_MIN = 7'd1;

    localparam logic [1:0] ACT_SET_PIXEL = 2'd0;
    localparam logic [1:0] ACT_CLEAR     = 2'd1;
    localparam logic [1:0] ACT_SCAN      = 2'd2;

    localparam logic [1:0] CFG_POWER      = 2'd0;
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd1;
    localparam logic [1:0] CFG_ROTATION   = 2'd2;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic ok;
        logic lower;
        row_t row;
        col_t col;
    } pix_target_t;

endpackage

`default_nettype wire

### sv/rgb_matrix_scan_driver_unit.sv
// ----------------------------------------------------------------------------
// rgb_matrix_scan_driver_unit
// Scan driver for a two-half RGB LED panel with a one-bit-per-colour store.
// ----------------------------------------------------------------------------
// The frame store is one synchronous RAM of HALF_ROWS x PANEL_COLUMNS words,
// each word holding the upper half pixel in bits 2:0 and the lower half pixel
// of the same scan row in bits 5:3, so a scan tick reads one word per column.
// A scan tick occupies the block from its accept cycle through the registered
// RAM read of each column in turn, held back while the output stalls, to the
// latch beat, and no new beat is accepted until it ends; it delivers
// PANEL_COLUMNS shift beats and one latch beat with tlast. A pixel write is a
// read-modify-write on the RAM, a read state and then a write state; a clear
// sweeps every word of the store after its accept cycle. After reset the same
// sweep runs before the first beat is accepted. Configuration writes are taken
// in any cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_matrix_scan_driver_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pos_x[5:0], pos_y[11:6], red[19:12], green[27:20], blue[35:28]
    input  wire logic [39:0] s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // row_address[3:0], upper_rgb[6:4], lower_rgb[9:7], on_time_us[16:10]
    output logic [23:0]      m_axis_tdata,
    // is_latch[0]
    output logic             m_axis_tuser,
    // last
    output logic             m_axis_tlast,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PRD   = 3'd2;
    localparam logic [2:0] ST_PWR   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;

    logic [2:0]                state_reg, state_next;
    rmsd_pkg::addr_t           clr_cnt_reg, clr_cnt_next;
    rmsd_pkg::col_cnt_t        col_cnt_reg, col_cnt_next;
    rmsd_pkg::row_t            scan_row_reg, scan_row_next;
    logic                      pend_reg, pend_next;

    logic                      power_reg, power_next;
    logic [6:0]                bright_reg, bright_next;
    logic [1:0]                rot_reg, rot_next;

    rmsd_pkg::pix_target_t     tgt;
    rmsd_pkg::row_t            pix_row_reg;
    rmsd_pkg::col_t            pix_col_reg;
    logic                      pix_lower_reg;
    logic [2:0]                pix_rgb_reg;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_latch_reg;
    rmsd_pkg::row_t            out_row_reg;
    logic [2:0]                out_up_reg;
    logic [2:0]                out_lo_reg;
    logic [6:0]                out_on_reg;

    logic                      in_beat;
    logic [1:0]                action;
    logic [2:0]                in_rgb;
    logic                      out_free;
    logic                      load_col;
    logic                      load_latch;
    logic                      issue;
    logic                      cols_done;

    logic                      ram_we;
    rmsd_pkg::addr_t           ram_waddr;
    rmsd_pkg::word_t           ram_wdata;
    logic                      ram_re;
    rmsd_pkg::addr_t           ram_raddr;
    rmsd_pkg::word_t           ram_rdata;
    rmsd_pkg::addr_t           pix_addr;
    rmsd_pkg::addr_t           scan_addr;

    rmsd_pixmap u_pixmap (
        .pos_x    (s_axis_tdata[5:0]),
        .pos_y    (s_axis_tdata[11:6]),
        .rotation (rot_reg),
        .target   (tgt)
    );

    rmsd_ram #(
        .WIDTH (rmsd_pkg::WORD_W),
        .DEPTH (rmsd_pkg::MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign action        = s_axis_tuser;
    assign in_rgb        = {|s_axis_tdata[35:28], |s_axis_tdata[27:20],
                            |s_axis_tdata[19:12]};

    assign pix_addr  = {pix_row_reg, pix_col_reg};
    assign scan_addr = {scan_row_reg, col_cnt_reg[rmsd_pkg::COL_W-1:0]};

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign cols_done  = (col_cnt_reg == rmsd_pkg::col_cnt_t'(rmsd_pkg::PANEL_COLUMNS));
    assign load_col   = (state_reg == ST_SCAN) && pend_reg && out_free;
    assign issue      = (state_reg == ST_SCAN) && !cols_done && (!pend_reg || load_col);
    assign load_latch = (state_reg == ST_SCAN) && cols_done && !pend_reg && out_free;

    // store port: sweep, pixel read-modify-write, scan reads
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_PWR);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : pix_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0
                     : (pix_lower_reg ? {pix_rgb_reg, ram_rdata[2:0]}
                                      : {ram_rdata[5:3], pix_rgb_reg});
    assign ram_re    = (state_reg == ST_PRD) || issue;
    assign ram_raddr = (state_reg == ST_PRD) ? pix_addr : scan_addr;

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        scan_row_next = scan_row_reg;
        pend_next     = pend_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == rmsd_pkg::addr_t'(rmsd_pkg::MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    priority if (action == rmsd_pkg::ACT_SET_PIXEL)
                    begin
                        if (tgt.ok)
                        begin
                            state_next = ST_PRD;
                        end
                    end
                    else if (action == rmsd_pkg::ACT_CLEAR)
                    begin
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end
                    else if (action == rmsd_pkg::ACT_SCAN)
                    begin
                        col_cnt_next = '0;
                        pend_next    = 1'b0;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PRD:
            begin
                state_next = ST_PWR;
            end
            ST_PWR:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    col_cnt_next = col_cnt_reg + 1'b1;
                    pend_next    = 1'b1;
                end
                else if (load_col)
                begin
                    pend_next = 1'b0;
                end
                if (load_latch)
                begin
                    if (scan_row_reg == rmsd_pkg::row_t'(rmsd_pkg::HALF_ROWS - 1))
                    begin
                        scan_row_next = '0;
                    end
                    else
                    begin
                        scan_row_next = scan_row_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        power_next  = power_reg;
        bright_next = bright_reg;
        rot_next    = rot_reg;
        if (cfg_valid && cfg_ready)
        begin
            priority if (cfg_index == rmsd_pkg::CFG_POWER)
            begin
                power_next = cfg_data[0];
            end
            else if (cfg_index == rmsd_pkg::CFG_BRIGHTNESS)
            begin
                priority if (cfg_data == 7'd0)
                begin
                    bright_next = rmsd_pkg::BRIGHT_MIN;
                end
                else if (cfg_data > rmsd_pkg::BRIGHT_MAX)
                begin
                    bright_next = rmsd_pkg::BRIGHT_MAX;
                end
                else
                begin
                    bright_next = cfg_data;
                end
            end
            else if (cfg_index == rmsd_pkg::CFG_ROTATION)
            begin
                rot_next = cfg_data[1:0];
            end
            else
            begin
                power_next = power_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_col || load_latch)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            scan_row_reg  <= '0;
            pend_reg      <= 1'b0;
            power_reg     <= 1'b1;
            bright_reg    <= rmsd_pkg::BRIGHT_MAX;
            rot_reg       <= rmsd_pkg::ROT_0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            scan_row_reg  <= scan_row_next;
            pend_reg      <= pend_next;
            power_reg     <= power_next;
            bright_reg    <= bright_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            pix_row_reg   <= tgt.row;
            pix_col_reg   <= tgt.col;
            pix_lower_reg <= tgt.lower;
            pix_rgb_reg   <= in_rgb;
        end
        if (load_col)
        begin
            out_latch_reg <= 1'b0;
            out_row_reg   <= scan_row_reg;
            out_up_reg    <= ram_rdata[2:0];
            out_lo_reg    <= ram_rdata[5:3];
            out_on_reg    <= 7'd0;
        end
        else if (load_latch)
        begin
            out_latch_reg <= 1'b1;
            out_row_reg   <= scan_row_reg;
            out_up_reg    <= 3'd0;
            out_lo_reg    <= 3'd0;
            out_on_reg    <= power_reg ? bright_reg : 7'd0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_latch_reg;
    assign m_axis_tlast  = out_latch_reg;
    assign m_axis_tdata  = {7'd0, out_on_reg, out_lo_reg, out_up_reg,
                            rmsd_pkg::row_addr_t'(out_row_reg)};

endmodule

`default_nettype wire

### sv/rmsd_ram.sv
// ----------------------------------------------------------------------------
// rmsd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/rmsd_pixmap.sv
// ----------------------------------------------------------------------------
// rmsd_pixmap
// Bounds check and quarter-turn rotation of a pixel coordinate, mapped onto
// a store row, a column and the upper or lower half slot.
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_pixmap (
    input  wire logic [5:0]           pos_x,
    input  wire logic [5:0]           pos_y,
    input  wire logic [1:0]           rotation,
    output rmsd_pkg::pix_target_t     target
);

    rmsd_pkg::coord_t sx;
    rmsd_pkg::coord_t sy;
    rmsd_pkg::coord_t nx;
    rmsd_pkg::coord_t ny;
    rmsd_pkg::coord_t row_full;
    logic             in_range;
    logic             lower;

    assign sx = rmsd_pkg::coord_t'({2'b00, pos_x});
    assign sy = rmsd_pkg::coord_t'({2'b00, pos_y});

    always_comb
    begin
        unique case (rotation)
            rmsd_pkg::ROT_90:
            begin
                nx = rmsd_pkg::ROWS_LAST - sy;
                ny = sx;
            end
            rmsd_pkg::ROT_180:
            begin
                nx = rmsd_pkg::ROWS_LAST - sx;
                ny = rmsd_pkg::COLS_LAST - sy;
            end
            rmsd_pkg::ROT_270:
            begin
                nx = sy;
                ny = rmsd_pkg::COLS_LAST - sx;
            end
            default:
            begin
                nx = sx;
                ny = sy;
            end
        endcase
    end

    // rows beyond the two scanned halves are never shown
    assign in_range = (sx < rmsd_pkg::ROWS_S) && (sy < rmsd_pkg::COLS_S)
                   && (nx >= 0) && (nx < rmsd_pkg::ROWS_S)
                   && (ny >= 0) && (ny < rmsd_pkg::COLS_S)
                   && (nx < rmsd_pkg::SCAN_ROWS_S);

    assign lower    = (nx >= rmsd_pkg::HALF_S);
    assign row_full = lower ? (nx - rmsd_pkg::HALF_S) : nx;

    assign target.ok    = in_range;
    assign target.lower = lower;
    assign target.row   = rmsd_pkg::row_t'(row_full);
    assign target.col   = rmsd_pkg::col_t'(ny);

endmodule

`default_nettype wire

### tb/rgb_matrix_scan_driver_checker.sv
// ----------------------------------------------------------------------------
// rgb_matrix_scan_driver_checker
// Watches the pixel, scan and register channels of the scan driver, keeps its
// own copy of the frame store, scan row and registers, works out every shift
// and latch beat a scan tick must produce and compares each output beat, field
// by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module rgb_matrix_scan_driver_checker
    import rmsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,

    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,
    input  wire logic        m_axis_tuser,
    input  wire logic        m_axis_tlast,

    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,

    output int               mismatches,
    output int               beats_due,
    output int               beats_checked
);

    typedef struct packed {
        logic       is_latch;
        row_addr_t  row_address;
        logic [2:0] upper_rgb;
        logic [2:0] lower_rgb;
        logic [6:0] on_time_us;
        logic       last;
    } scan_beat_t;

    logic [2:0] frame_bits [PANEL_ROWS][PANEL_COLUMNS];
    row_addr_t  scan_row_now;
    logic       power_now;
    logic [6:0] brightness_now;
    logic [1:0] rotation_now;

    scan_beat_t shift_latch_beats [$];
    int         fail_count;
    int         checked_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 30)
            $display("beat %0d: %s mismatch, got %0d expected %0d",
                     checked_count, what, got, want);
        fail_count++;
    endtask

    task automatic clear_frame();
        for (int r = 0; r < PANEL_ROWS; r++)
            for (int c = 0; c < PANEL_COLUMNS; c++)
                frame_bits[r][c] = 3'b000;
    endtask

    task automatic apply_register(input logic [1:0] idx, input logic [6:0] val);
        case (idx)
            CFG_POWER:      power_now = val[0];
            CFG_BRIGHTNESS:
            begin
                if (val == 7'd0)
                    brightness_now = BRIGHT_MIN;
                else if (val > BRIGHT_MAX)
                    brightness_now = BRIGHT_MAX;
                else
                    brightness_now = val;
            end
            CFG_ROTATION:   rotation_now = val[1:0];
            default:        ;
        endcase
    endtask

    task automatic predict_panel_item(input logic [1:0] act, input logic [39:0] d);
        int         x;
        int         y;
        int         nx;
        int         ny;
        int         r;
        scan_beat_t b;

        x = d[5:0];
        y = d[11:6];
        case (act)
            ACT_SET_PIXEL:
            begin
                if (x < PANEL_ROWS && y < PANEL_COLUMNS)
                begin
                    case (rotation_now)
                        ROT_90:
                        begin
                            nx = PANEL_ROWS - 1 - y;
                            ny = x;
                        end
                        ROT_180:
                        begin
                            nx = PANEL_ROWS - 1 - x;
                            ny = PANEL_COLUMNS - 1 - y;
                        end
                        ROT_270:
                        begin
                            nx = y;
                            ny = PANEL_COLUMNS - 1 - x;
                        end
                        default:
                        begin
                            nx = x;
                            ny = y;
                        end
                    endcase
                    if (nx >= 0 && nx < PANEL_ROWS && ny >= 0 && ny < PANEL_COLUMNS)
                        frame_bits[nx][ny] = {|d[35:28], |d[27:20], |d[19:12]};
                end
            end
            ACT_CLEAR:
                clear_frame();
            ACT_SCAN:
            begin
                r = scan_row_now;
                if (r >= HALF_ROWS)
                    r = 0;
                for (int c = 0; c < PANEL_COLUMNS; c++)
                begin
                    b = '0;
                    b.row_address = r[3:0];
                    b.upper_rgb   = frame_bits[r][c];
                    b.lower_rgb   = frame_bits[r + HALF_ROWS][c];
                    shift_latch_beats.push_back(b);
                end
                b = '0;
                b.is_latch    = 1'b1;
                b.row_address = r[3:0];
                b.on_time_us  = power_now ? brightness_now : 7'd0;
                b.last        = 1'b1;
                shift_latch_beats.push_back(b);
                r++;
                if (r >= HALF_ROWS)
                    r = 0;
                scan_row_now = r[3:0];
            end
            default: ;
        endcase
    endtask

    task automatic check_beat();
        scan_beat_t want;

        if (shift_latch_beats.size() == 0)
        begin
            report_mismatch("beat with nothing due, is_latch", m_axis_tuser, 0);
        end
        else
        begin
            want = shift_latch_beats.pop_front();
            if (m_axis_tuser !== want.is_latch)
                report_mismatch("is_latch", m_axis_tuser, want.is_latch);
            if (m_axis_tdata[3:0] !== want.row_address)
                report_mismatch("row_address", m_axis_tdata[3:0], want.row_address);
            if (m_axis_tdata[6:4] !== want.upper_rgb)
                report_mismatch("upper_rgb", m_axis_tdata[6:4], want.upper_rgb);
            if (m_axis_tdata[9:7] !== want.lower_rgb)
                report_mismatch("lower_rgb", m_axis_tdata[9:7], want.lower_rgb);
            if (m_axis_tdata[16:10] !== want.on_time_us)
                report_mismatch("on_time_us", m_axis_tdata[16:10], want.on_time_us);
            if (m_axis_tlast !== want.last)
                report_mismatch("last", m_axis_tlast, want.last);
        end
        checked_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            scan_row_now   = '0;
            power_now      = 1'b1;
            brightness_now = BRIGHT_MAX;
            rotation_now   = ROT_0;
            shift_latch_beats.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                predict_panel_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
        end
        mismatches    <= fail_count;
        beats_due     <= shift_latch_beats.size();
        beats_checked <= checked_count;
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the RGB matrix scan driver with pixel writes, clears, scan ticks and
// unused action codes, first a directed set around the panel corners, the
// half boundary and out-of-range coordinates, then random phases under
// several power, brightness and rotation settings. The sender runs in random
// bursts and the receiver stalls in changing patterns; a separate checker
// predicts and compares every output beat.
// ----------------------------------------------------------------------------
module testbench;
    import rmsd_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         DRAIN_WAIT  = 600;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;

    int          mismatches;
    int          beats_due;
    int          beats_checked;

    int          cycle_count = 0;
    int          burst_left = 0;
    int          pixel_items = 0;
    int          scan_items = 0;
    int          clear_items = 0;
    int          unused_items = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    logic [15:0] stall_pattern = 16'hffff;

    logic       power_plan  [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    logic [6:0] bright_plan [PHASES] = '{7'd127, 7'd50, 7'd0, 7'd100, 7'd1, 7'd77};
    logic [1:0] rot_plan    [PHASES] = '{ROT_90, ROT_180, ROT_270, ROT_0, ROT_180, ROT_90};

    rgb_matrix_scan_driver_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rgb_matrix_scan_driver_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .beats_due     (beats_due),
        .beats_checked (beats_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still due", cycle_count, beats_due);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall patterns, each held for a random stretch
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode    = $urandom_range(0, 3);
            stall_left    = $urandom_range(30, 300);
            stall_pattern = $urandom;
        end
        stall_left--;
        stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= stall_pattern[0];
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [39:0] pixel_beat(input int x, input int y,
                                               input int r, input int g, input int b);
        return {4'b0000, b[7:0], g[7:0], r[7:0], y[5:0], x[5:0]};
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [39:0] data);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(40, 80);
            else
                burst_left = $urandom_range(1, 20);
        end
        s_tuser  <= act;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        case (act)
            ACT_SET_PIXEL: pixel_items++;
            ACT_CLEAR:     clear_items++;
            ACT_SCAN:      scan_items++;
            default:       unused_items++;
        endcase
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (beats_due != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_level(output int level);
        if ($urandom_range(0, 9) < 3)
            level = 0;
        else if ($urandom_range(0, 9) == 0)
            level = 255;
        else
            level = $urandom_range(0, 255);
    endtask

    initial
    begin
        int         sent;
        int         pick;
        int         x;
        int         y;
        int         r;
        int         g;
        int         b;
        logic [1:0] act;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners, half boundary and each colour alone under reset settings
        send_item(ACT_SET_PIXEL, pixel_beat(0, 0, 255, 255, 255));
        send_item(ACT_SET_PIXEL, pixel_beat(16, 0, 0, 255, 0));
        send_item(ACT_SET_PIXEL, pixel_beat(31, 31, 1, 0, 0));
        send_item(ACT_SET_PIXEL, pixel_beat(0, 31, 0, 0, 128));
        send_item(ACT_SET_PIXEL, pixel_beat(17, 31, 200, 0, 7));
        send_item(ACT_SET_PIXEL, pixel_beat(1, 5, 0, 1, 1));
        send_item(ACT_SET_PIXEL, pixel_beat(15, 16, 255, 0, 255));
        // coordinates off the panel are dropped
        send_item(ACT_SET_PIXEL, pixel_beat(32, 3, 255, 255, 255));
        send_item(ACT_SET_PIXEL, pixel_beat(5, 32, 255, 255, 255));
        send_item(ACT_SET_PIXEL, pixel_beat(63, 63, 255, 255, 255));
        send_item(ACT_SET_PIXEL, pixel_beat(1, 63, 255, 255, 255));
        send_item(ACT_UNUSED, 40'h0f_ffff_ffff);
        send_item(ACT_SCAN, '0);
        send_item(ACT_SCAN, '0);
        // overwrite with all colours zero
        send_item(ACT_SET_PIXEL, pixel_beat(0, 0, 0, 0, 0));
        send_item(ACT_SET_PIXEL, pixel_beat(2, 7, 0, 0, 0));
        send_item(ACT_SCAN, '0);
        send_item(ACT_CLEAR, '0);
        send_item(ACT_SCAN, '0);
        send_item(ACT_SET_PIXEL, pixel_beat(4, 9, 9, 9, 9));
        send_item(ACT_SCAN, '0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            if (phase == PHASES - 1)
            begin
                write_reg(CFG_POWER, 7'($urandom_range(0, 1)));
                write_reg(CFG_BRIGHTNESS, 7'($urandom_range(0, 127)));
                write_reg(CFG_ROTATION, 7'($urandom_range(0, 3)));
            end
            else
            begin
                write_reg(CFG_POWER, {6'd0, power_plan[phase]});
                write_reg(CFG_BRIGHTNESS, bright_plan[phase]);
                write_reg(CFG_ROTATION, {5'd0, rot_plan[phase]});
            end
            if (phase == 3)
                write_reg(CFG_UNUSED, 7'($urandom_range(0, 127)));
            cfg_valid <= 1'b0;
            @(posedge clk);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 48)
                    act = ACT_SET_PIXEL;
                else if (pick < 88)
                    act = ACT_SCAN;
                else if (pick < 92)
                    act = ACT_CLEAR;
                else
                    act = ACT_UNUSED;
                if ($urandom_range(0, 99) < 85)
                begin
                    x = $urandom_range(0, PANEL_ROWS - 1);
                    y = $urandom_range(0, PANEL_COLUMNS - 1);
                end
                else
                begin
                    x = $urandom_range(0, 63);
                    y = $urandom_range(0, 63);
                end
                random_level(r);
                random_level(g);
                random_level(b);
                send_item(act, pixel_beat(x, y, r, g, b));
                if (act != ACT_UNUSED)
                    sent++;
            end
        end

        wait_idle();
        $display("items: %0d pixel writes, %0d scans, %0d clears, %0d unused codes",
                 pixel_items, scan_items, clear_items, unused_items);
        $display("%0d output beats checked over %0d register settings in %0d cycles",
                 beats_checked, PHASES + 1, cycle_count);
        if (mismatches == 0 && beats_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
